// File: rtl/afsc_pkg.sv
// Shared types and codes for the autofocus sweep controller.
package afsc_pkg;

  // Event codes on the input channel
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_SCORE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Action codes on the result channel
  typedef enum logic [2:0] {
    ACT_BEGIN         = 3'd0,
    ACT_MOVE_STAGE    = 3'd1,
    ACT_MOVE_FOCUS    = 3'd2,
    ACT_CAPTURE       = 3'd3,
    ACT_RELEASE       = 3'd4,
    ACT_CAPTURE_FINAL = 3'd5,
    ACT_DONE          = 3'd6,
    ACT_SPARE         = 3'd7
  } action_t;

  // Sweep sequencer phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE         = 5'b00001,
    PH_STAGE_SETTLE = 5'b00010,
    PH_FOCUS_SETTLE = 5'b00100,
    PH_WAIT_SCORE   = 5'b01000,
    PH_FINAL_SETTLE = 5'b10000
  } phase_t;

  // Configuration register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_STAGE_START  = 3'd0;
  localparam logic [2:0] REG_STAGE_STEP   = 3'd1;
  localparam logic [2:0] REG_STAGE_STOP   = 3'd2;
  localparam logic [2:0] REG_FOCUS_START  = 3'd3;
  localparam logic [2:0] REG_FOCUS_STEP   = 3'd4;
  localparam logic [2:0] REG_FOCUS_STOP   = 3'd5;
  localparam logic [2:0] REG_STAGE_SETTLE = 3'd6;
  localparam logic [2:0] REG_FOCUS_SETTLE = 3'd7;

  // Maximum results caused by one item
  localparam int MAX_RESULTS = 3;

endpackage

// File: rtl/autofocus_sweep_controller_core.sv
// Top level of the two-axis autofocus sweep controller.
//
// Sequences a nested stage/focus sweep driven by events on the input channel
// (tick, start sweep, frame score) and reports actions on the result channel
// (begin, move stage, move focus, capture, release, capture final, done),
// each tagged with the best stage, focus and score found so far. Settle
// delays are counted in ticks: after a move the block swallows that many
// ticks, then acts on the next one. The strictly highest score wins; a new
// sweep clears the best score. Next positions are formed one bit wider than
// the position so a sweep never wraps; a zero step acts as one. Events out
// of place (start outside idle, score outside the wait, ticks while idle or
// waiting, the unused code) are dropped and give no result. Each item is
// decided in the cycle it is accepted; its results, up to three, are held
// in a three-entry result register, shown one per cycle while out_ready is
// high, last set on the final one. A new item is taken while the final
// result of the previous one is being taken, so one-result items run at
// one item per cycle while out_ready is high. An item giving no result
// leaves the result register empty, so the next item can follow it at
// once. Registers are written over the APB port and take effect at once,
// also in the middle of a sweep; write them only while no item or result
// is in flight.
module autofocus_sweep_controller_core #(
  parameter int POS_WIDTH   = 16,
  parameter int SCORE_WIDTH = 16,
  parameter int TIMER_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // event channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  afsc_pkg::cmd_t                cmd,
  input  logic [SCORE_WIDTH-1:0]        score,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output afsc_pkg::action_t             action,
  output logic signed [POS_WIDTH-1:0]   position,
  output logic signed [POS_WIDTH-1:0]   best_stage,
  output logic signed [POS_WIDTH-1:0]   best_focus,
  output logic [SCORE_WIDTH-1:0]        best_score,
  output logic                          last
);

  import afsc_pkg::*;

  localparam int STEP_WIDTH = POS_WIDTH - 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [POS_WIDTH-1:0]   stage_start_reg;
  logic [STEP_WIDTH-1:0]  stage_step_reg;
  logic [POS_WIDTH-1:0]   stage_stop_reg;
  logic [POS_WIDTH-1:0]   focus_start_reg;
  logic [STEP_WIDTH-1:0]  focus_step_reg;
  logic [POS_WIDTH-1:0]   focus_stop_reg;
  logic [TIMER_WIDTH-1:0] stage_settle_reg;
  logic [TIMER_WIDTH-1:0] focus_settle_reg;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_start_reg  <= '0;
      stage_step_reg   <= STEP_WIDTH'(1);
      stage_stop_reg   <= '0;
      focus_start_reg  <= '0;
      focus_step_reg   <= STEP_WIDTH'(1);
      focus_stop_reg   <= '0;
      stage_settle_reg <= '0;
      focus_settle_reg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STAGE_START:  stage_start_reg  <= pwdata[POS_WIDTH-1:0];
        REG_STAGE_STEP:   stage_step_reg   <= pwdata[STEP_WIDTH-1:0];
        REG_STAGE_STOP:   stage_stop_reg   <= pwdata[POS_WIDTH-1:0];
        REG_FOCUS_START:  focus_start_reg  <= pwdata[POS_WIDTH-1:0];
        REG_FOCUS_STEP:   focus_step_reg   <= pwdata[STEP_WIDTH-1:0];
        REG_FOCUS_STOP:   focus_stop_reg   <= pwdata[POS_WIDTH-1:0];
        REG_STAGE_SETTLE: stage_settle_reg <= pwdata[TIMER_WIDTH-1:0];
        REG_FOCUS_SETTLE: focus_settle_reg <= pwdata[TIMER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read back raw register bits, zero-extended
  always_comb begin
    unique case (cfg_index)
      REG_STAGE_START:  prdata = 32'(stage_start_reg);
      REG_STAGE_STEP:   prdata = 32'(stage_step_reg);
      REG_STAGE_STOP:   prdata = 32'(stage_stop_reg);
      REG_FOCUS_START:  prdata = 32'(focus_start_reg);
      REG_FOCUS_STEP:   prdata = 32'(focus_step_reg);
      REG_FOCUS_STOP:   prdata = 32'(focus_stop_reg);
      REG_STAGE_SETTLE: prdata = 32'(stage_settle_reg);
      REG_FOCUS_SETTLE: prdata = 32'(focus_settle_reg);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sweep state
  // ---------------------------------------------------------------------
  phase_t                  phase, phase_next;
  logic [POS_WIDTH-1:0]    cur_stage, cur_stage_next;
  logic [POS_WIDTH-1:0]    cur_focus, cur_focus_next;
  logic [POS_WIDTH-1:0]    best_stage_reg, best_stage_next;
  logic [POS_WIDTH-1:0]    best_focus_reg, best_focus_next;
  logic [SCORE_WIDTH-1:0]  best_score_reg, best_score_next;
  logic                    best_valid, best_valid_next;
  logic [TIMER_WIDTH-1:0]  settle_count, settle_count_next;

  // Results of the item being accepted
  logic [1:0]              res_count;
  action_t                 res_action [MAX_RESULTS];
  logic [POS_WIDTH-1:0]    res_pos    [MAX_RESULTS];

  // Result register: entry 0 is on the port, the rest queue behind it
  logic [1:0]              buf_count;
  action_t                 buf_action [MAX_RESULTS];
  logic [POS_WIDTH-1:0]    buf_pos    [MAX_RESULTS];
  logic [POS_WIDTH-1:0]    buf_best_stage;
  logic [POS_WIDTH-1:0]    buf_best_focus;
  logic [SCORE_WIDTH-1:0]  buf_best_score;

  logic in_accept;
  logic out_accept;

  assign out_valid  = (buf_count != 2'd0);
  assign out_accept = out_valid & out_ready;
  // Take a new item once the result register empties in this cycle
  assign in_ready   = (buf_count == 2'd0) || ((buf_count == 2'd1) && out_ready);
  assign in_accept  = in_valid & in_ready;

  // Next positions, one bit wider so they never wrap
  logic [STEP_WIDTH-1:0]         focus_step_eff, stage_step_eff;
  logic signed [POS_WIDTH:0]     focus_sum, stage_sum;
  logic signed [POS_WIDTH:0]     focus_limit, stage_limit;
  logic                          focus_fits, stage_fits;
  logic                          score_wins;

  always_comb begin
    focus_step_eff = (focus_step_reg == '0) ? STEP_WIDTH'(1) : focus_step_reg;
    stage_step_eff = (stage_step_reg == '0) ? STEP_WIDTH'(1) : stage_step_reg;
    focus_sum   = $signed({cur_focus[POS_WIDTH-1], cur_focus})
                + $signed({2'b00, focus_step_eff});
    stage_sum   = $signed({cur_stage[POS_WIDTH-1], cur_stage})
                + $signed({2'b00, stage_step_eff});
    focus_limit = $signed({focus_stop_reg[POS_WIDTH-1], focus_stop_reg});
    stage_limit = $signed({stage_stop_reg[POS_WIDTH-1], stage_stop_reg});
    focus_fits  = (focus_sum <= focus_limit);
    stage_fits  = (stage_sum <= stage_limit);
    score_wins  = !best_valid || (score > best_score_reg);
  end

  // Decide the item against the current state
  always_comb begin
    phase_next        = phase;
    cur_stage_next    = cur_stage;
    cur_focus_next    = cur_focus;
    best_stage_next   = best_stage_reg;
    best_focus_next   = best_focus_reg;
    best_score_next   = best_score_reg;
    best_valid_next   = best_valid;
    settle_count_next = settle_count;
    res_count         = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_action[i] = ACT_BEGIN;
      res_pos[i]    = '0;
    end

    if (in_accept) begin
      if (cmd == CMD_START && phase == PH_IDLE) begin
        // New sweep: best position starts at the first point, score cleared
        cur_stage_next    = stage_start_reg;
        cur_focus_next    = focus_start_reg;
        best_stage_next   = stage_start_reg;
        best_focus_next   = focus_start_reg;
        best_score_next   = '0;
        best_valid_next   = 1'b0;
        res_action[0]     = ACT_BEGIN;
        res_action[1]     = ACT_MOVE_STAGE;
        res_pos[1]        = stage_start_reg;
        res_count         = 2'd2;
        settle_count_next = stage_settle_reg;
        phase_next        = PH_STAGE_SETTLE;
      end else if (cmd == CMD_TICK && (phase == PH_STAGE_SETTLE ||
                   phase == PH_FOCUS_SETTLE || phase == PH_FINAL_SETTLE)) begin
        if (settle_count != '0) begin
          settle_count_next = settle_count - TIMER_WIDTH'(1);
        end else if (phase == PH_STAGE_SETTLE) begin
          res_action[0]     = ACT_MOVE_FOCUS;
          res_pos[0]        = cur_focus;
          res_count         = 2'd1;
          settle_count_next = focus_settle_reg;
          phase_next        = PH_FOCUS_SETTLE;
        end else if (phase == PH_FOCUS_SETTLE) begin
          res_action[0] = ACT_CAPTURE;
          res_count     = 2'd1;
          phase_next    = PH_WAIT_SCORE;
        end else begin
          res_action[0] = ACT_CAPTURE_FINAL;
          res_action[1] = ACT_DONE;
          res_count     = 2'd2;
          phase_next    = PH_IDLE;
        end
      end else if (cmd == CMD_SCORE && phase == PH_WAIT_SCORE) begin
        if (score_wins) begin
          best_score_next = score;
          best_stage_next = cur_stage;
          best_focus_next = cur_focus;
          best_valid_next = 1'b1;
        end
        res_action[0] = ACT_RELEASE;
        if (focus_fits) begin
          // advance along the row
          cur_focus_next    = focus_sum[POS_WIDTH-1:0];
          res_action[1]     = ACT_MOVE_FOCUS;
          res_pos[1]        = focus_sum[POS_WIDTH-1:0];
          res_count         = 2'd2;
          settle_count_next = focus_settle_reg;
          phase_next        = PH_FOCUS_SETTLE;
        end else if (stage_fits) begin
          // advance to the next row, focus restarts
          cur_stage_next    = stage_sum[POS_WIDTH-1:0];
          cur_focus_next    = focus_start_reg;
          res_action[1]     = ACT_MOVE_STAGE;
          res_pos[1]        = stage_sum[POS_WIDTH-1:0];
          res_count         = 2'd2;
          settle_count_next = stage_settle_reg;
          phase_next        = PH_STAGE_SETTLE;
        end else begin
          // sweep done: return to the best point
          res_action[1]     = ACT_MOVE_FOCUS;
          res_pos[1]        = best_focus_next;
          res_action[2]     = ACT_MOVE_STAGE;
          res_pos[2]        = best_stage_next;
          res_count         = 2'd3;
          settle_count_next = stage_settle_reg;
          phase_next        = PH_FINAL_SETTLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      cur_stage      <= '0;
      cur_focus      <= '0;
      best_stage_reg <= '0;
      best_focus_reg <= '0;
      best_score_reg <= '0;
      best_valid     <= 1'b0;
      settle_count   <= '0;
    end else begin
      phase          <= phase_next;
      cur_stage      <= cur_stage_next;
      cur_focus      <= cur_focus_next;
      best_stage_reg <= best_stage_next;
      best_focus_reg <= best_focus_next;
      best_score_reg <= best_score_next;
      best_valid     <= best_valid_next;
      settle_count   <= settle_count_next;
    end
  end

  // Result register: count is control, payload holds without reset
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= 2'd0;
    end else if (in_accept) begin
      buf_count <= res_count;
    end else if (out_accept) begin
      buf_count <= buf_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        buf_action[i] <= res_action[i];
        buf_pos[i]    <= res_pos[i];
      end
      buf_best_stage <= best_stage_next;
      buf_best_focus <= best_focus_next;
      buf_best_score <= best_score_next;
    end else if (out_accept) begin
      // advance the queue by one entry
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        buf_action[i] <= buf_action[i+1];
        buf_pos[i]    <= buf_pos[i+1];
      end
    end
  end

  assign action     = buf_action[0];
  assign position   = buf_pos[0];
  assign best_stage = buf_best_stage;
  assign best_focus = buf_best_focus;
  assign best_score = buf_best_score;
  assign last       = (buf_count == 2'd1);

endmodule

// File: tb/sv/tb_autofocus_sweep_controller_core.sv
// Self-checking testbench for the autofocus sweep controller core.
`timescale 1ns / 1ps

module tb_autofocus_sweep_controller_core;
  import afsc_pkg::*;

  // Give up after this many cycles in which no item, result or register write moves.
  localparam int STALL_LIMIT = 2000;
  // Random part stops once this many events have actually been acted upon.
  localparam int RANDOM_EVENTS = 240;
  // Settle count used for the long settle run at the end.
  localparam int LONG_SETTLE = 30;

  // One action as it should appear on the result channel.
  typedef struct packed {
    action_t            action;
    logic signed [15:0] position;
    logic signed [15:0] best_stage;
    logic signed [15:0] best_focus;
    logic [15:0]        best_score;
    logic               last;
  } act_rec_t;

  // One event waiting to be driven, together with the actions it must cause.
  typedef struct packed {
    cmd_t            cmd;
    logic [15:0]     score;
    logic [3:0]      gap;
    logic [1:0]      n_acts;
    act_rec_t [2:0]  acts;
  } sweep_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  logic in_valid, in_ready;
  cmd_t cmd;
  logic [15:0] score;

  logic               out_valid, out_ready;
  action_t            action;
  logic signed [15:0] position, best_stage, best_focus;
  logic [15:0]        best_score;
  logic               last;

  // Events still to be driven, and actions owed by events already accepted.
  sweep_event_t event_q[$];
  act_rec_t     due_acts[$];
  sweep_event_t on_wire;

  int  in_hold;
  int  out_hold;
  int  idle_cycles;
  int  fail_cnt;
  int  taken_cnt;
  int  phase_goal;
  bit  calm;
  bit  ev_taken;

  act_rec_t mon_seen, mon_want;
  int       mon_wait;

  // Shadow copy of the controller: register file and sweep state.
  logic signed [15:0] cfg_stage_start, cfg_stage_stop, cfg_focus_start, cfg_focus_stop;
  logic [14:0]        cfg_stage_step, cfg_focus_step;
  logic [15:0]        cfg_stage_settle, cfg_focus_settle;

  phase_t             sw_phase;
  logic signed [16:0] cur_stage_p, cur_focus_p;
  logic signed [15:0] best_stage_p, best_focus_p;
  logic [15:0]        best_score_p;
  logic               best_ok;
  logic [15:0]        settle_left;

  autofocus_sweep_controller_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .score      (score),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .action     (action),
    .position   (position),
    .best_stage (best_stage),
    .best_focus (best_focus),
    .best_score (best_score),
    .last       (last)
  );

  always #6 clk = ~clk;

  // Idle cycles before the next item or result; zero throughout a calm stretch.
  function automatic int draw_wait();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  // A step register of zero behaves as a step of one.
  function automatic logic [14:0] unit_step(logic [14:0] s);
    return (s == '0) ? 15'd1 : s;
  endfunction

  // Stamp an action with the best-so-far figures as they stand now.
  function automatic act_rec_t make_act(action_t a, logic signed [15:0] pos);
    act_rec_t r;
    r.action     = a;
    r.position   = pos;
    r.best_stage = best_stage_p;
    r.best_focus = best_focus_p;
    r.best_score = best_ok ? best_score_p : 16'h0000;
    r.last       = 1'b0;
    return r;
  endfunction

  // Advance the shadow sweep by one event and return the actions it causes.
  // Events that arrive out of place leave the state alone and clear ev_taken.
  function automatic sweep_event_t advance_sweep(cmd_t c, logic [15:0] sc);
    sweep_event_t       ev;
    logic signed [16:0] nxt;
    int                 n;
    ev       = '0;
    ev.cmd   = c;
    ev.score = sc;
    n        = 0;
    ev_taken = 1'b0;
    if (c == CMD_START && sw_phase == PH_IDLE) begin
      // New sweep: best position restarts at the start corner, score invalid.
      ev_taken     = 1'b1;
      cur_stage_p  = 17'(cfg_stage_start);
      cur_focus_p  = 17'(cfg_focus_start);
      best_stage_p = cfg_stage_start;
      best_focus_p = cfg_focus_start;
      best_score_p = '0;
      best_ok      = 1'b0;
      ev.acts[n]   = make_act(ACT_BEGIN, '0);
      n++;
      ev.acts[n]   = make_act(ACT_MOVE_STAGE, cfg_stage_start);
      n++;
      settle_left  = cfg_stage_settle;
      sw_phase     = PH_STAGE_SETTLE;
    end else if (c == CMD_TICK && (sw_phase == PH_STAGE_SETTLE ||
                                   sw_phase == PH_FOCUS_SETTLE ||
                                   sw_phase == PH_FINAL_SETTLE)) begin
      ev_taken = 1'b1;
      if (settle_left != '0) begin
        settle_left = settle_left - 16'd1;
      end else if (sw_phase == PH_STAGE_SETTLE) begin
        ev.acts[n]  = make_act(ACT_MOVE_FOCUS, cur_focus_p[15:0]);
        n++;
        settle_left = cfg_focus_settle;
        sw_phase    = PH_FOCUS_SETTLE;
      end else if (sw_phase == PH_FOCUS_SETTLE) begin
        ev.acts[n] = make_act(ACT_CAPTURE, '0);
        n++;
        sw_phase   = PH_WAIT_SCORE;
      end else begin
        ev.acts[n] = make_act(ACT_CAPTURE_FINAL, '0);
        n++;
        ev.acts[n] = make_act(ACT_DONE, '0);
        n++;
        sw_phase   = PH_IDLE;
      end
    end else if (c == CMD_SCORE && sw_phase == PH_WAIT_SCORE) begin
      ev_taken = 1'b1;
      // Strictly higher wins; the first score of a sweep always wins.
      if (!best_ok || sc > best_score_p) begin
        best_score_p = sc;
        best_stage_p = cur_stage_p[15:0];
        best_focus_p = cur_focus_p[15:0];
        best_ok      = 1'b1;
      end
      ev.acts[n] = make_act(ACT_RELEASE, '0);
      n++;
      // Form the next position one bit wider so the sweep never wraps.
      nxt = cur_focus_p + $signed({2'b00, unit_step(cfg_focus_step)});
      if (nxt <= cfg_focus_stop) begin
        cur_focus_p = nxt;
        ev.acts[n]  = make_act(ACT_MOVE_FOCUS, nxt[15:0]);
        n++;
        settle_left = cfg_focus_settle;
        sw_phase    = PH_FOCUS_SETTLE;
      end else begin
        nxt = cur_stage_p + $signed({2'b00, unit_step(cfg_stage_step)});
        if (nxt <= cfg_stage_stop) begin
          cur_stage_p = nxt;
          cur_focus_p = 17'(cfg_focus_start);
          ev.acts[n]  = make_act(ACT_MOVE_STAGE, nxt[15:0]);
          n++;
          settle_left = cfg_stage_settle;
          sw_phase    = PH_STAGE_SETTLE;
        end else begin
          // Past the last row: return to the best corner and settle there.
          ev.acts[n]  = make_act(ACT_MOVE_FOCUS, best_focus_p);
          n++;
          ev.acts[n]  = make_act(ACT_MOVE_STAGE, best_stage_p);
          n++;
          settle_left = cfg_stage_settle;
          sw_phase    = PH_FINAL_SETTLE;
        end
      end
    end
    if (n > 0) ev.acts[n-1].last = 1'b1;
    ev.n_acts = n[1:0];
    return ev;
  endfunction

  // Predict an event, give it a lead-in gap and put it in line for the driver.
  task automatic queue_event(cmd_t c, logic [15:0] sc);
    sweep_event_t ev;
    ev     = advance_sweep(c, sc);
    ev.gap = 4'(draw_wait());
    event_q.push_back(ev);
    if (ev_taken) taken_cnt++;
  endtask

  // Scores lean towards the extremes and towards ties with the current best.
  function automatic logic [15:0] pick_score();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return best_score_p;
      default: return 16'($urandom());
    endcase
  endfunction

  // Queue the event the sweep is waiting for in its current phase.
  task automatic queue_proper();
    case (sw_phase)
      PH_IDLE:       queue_event(CMD_START, 16'($urandom()));
      PH_WAIT_SCORE: queue_event(CMD_SCORE, pick_score());
      default:       queue_event(CMD_TICK, 16'($urandom()));
    endcase
  endtask

  // Write one register; the bits above the field carry noise the block must drop.
  task automatic apb_write(logic [2:0] idx, int value);
    logic [31:0] d;
    d = $urandom();
    if (idx == REG_STAGE_STEP || idx == REG_FOCUS_STEP) d[14:0] = value[14:0];
    else d[15:0] = value[15:0];
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The access phase completes at this edge.
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STAGE_START:  cfg_stage_start  = d[15:0];
      REG_STAGE_STEP:   cfg_stage_step   = d[14:0];
      REG_STAGE_STOP:   cfg_stage_stop   = d[15:0];
      REG_FOCUS_START:  cfg_focus_start  = d[15:0];
      REG_FOCUS_STEP:   cfg_focus_step   = d[14:0];
      REG_FOCUS_STOP:   cfg_focus_stop   = d[15:0];
      REG_STAGE_SETTLE: cfg_stage_settle = d[15:0];
      default:          cfg_focus_settle = d[15:0];
    endcase
  endtask

  // Pick start, step and stop for one axis: a few rows at most, extremes mixed in.
  task automatic pick_axis(output int first, output int stride, output int bound);
    int eff;
    case ($urandom_range(0, 5))
      0: first = -32768;
      1: first = 32767;
      default: first = int'($urandom_range(0, 65535)) - 32768;
    endcase
    case ($urandom_range(0, 5))
      0: stride = 0;
      1: stride = 32767;
      default: stride = $urandom_range(1, 3000);
    endcase
    eff   = (stride == 0) ? 1 : stride;
    bound = first + eff * int'($urandom_range(0, 3)) + int'($urandom_range(0, eff - 1));
    if ($urandom_range(0, 7) == 0) bound = first - int'($urandom_range(1, 100));
    if (bound > 32767) bound = 32767;
    if (bound < -32768) bound = -32768;
  endtask

  function automatic int pick_settle();
    if ($urandom_range(0, 9) == 0) return $urandom_range(4, 24);
    return $urandom_range(0, 3);
  endfunction

  // Rewrite a random subset of the registers, often in the middle of a sweep.
  task automatic retune();
    int s0, s1, s2, f0, f1, f2;
    pick_axis(s0, s1, s2);
    pick_axis(f0, f1, f2);
    if ($urandom_range(0, 2) != 0) apb_write(REG_STAGE_START, s0);
    if ($urandom_range(0, 2) != 0) apb_write(REG_STAGE_STEP, s1);
    if ($urandom_range(0, 2) != 0) apb_write(REG_STAGE_STOP, s2);
    if ($urandom_range(0, 2) != 0) apb_write(REG_FOCUS_START, f0);
    if ($urandom_range(0, 2) != 0) apb_write(REG_FOCUS_STEP, f1);
    if ($urandom_range(0, 2) != 0) apb_write(REG_FOCUS_STOP, f2);
    if ($urandom_range(0, 2) != 0) apb_write(REG_STAGE_SETTLE, pick_settle());
    if ($urandom_range(0, 2) != 0) apb_write(REG_FOCUS_SETTLE, pick_settle());
  endtask

  // Wait until every queued event is in and every owed action is out, then a
  // few more cycles for an event that produced nothing to finish inside the block.
  task automatic quiesce();
    do @(negedge clk); while (event_q.size() != 0 || in_valid || due_acts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Driver: on acceptance, hand the event's actions to the scoreboard; then
  // hold off for the next event's gap and present it. in_valid is assigned
  // once per edge, so a back-to-back event keeps it high without a glitch.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cmd      <= CMD_TICK;
      score    <= '0;
      in_hold  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        for (int k = 0; k < on_wire.n_acts; k++) due_acts.push_back(on_wire.acts[k]);
      end
      if (!in_valid || in_ready) begin
        if (event_q.size() != 0 && in_hold >= event_q[0].gap) begin
          on_wire  = event_q.pop_front();
          in_valid <= 1'b1;
          cmd      <= on_wire.cmd;
          score    <= on_wire.score;
          in_hold  <= 0;
        end else begin
          in_valid <= 1'b0;
          if (event_q.size() != 0) in_hold <= in_hold + 1;
        end
      end
    end
  end

  // Monitor: check each accepted action against the oldest owed one, then
  // stall the result channel for a freshly drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      out_hold  <= 0;
    end else if (out_valid && out_ready) begin
      mon_seen.action     = action;
      mon_seen.position   = position;
      mon_seen.best_stage = best_stage;
      mon_seen.best_focus = best_focus;
      mon_seen.best_score = best_score;
      mon_seen.last       = last;
      if (due_acts.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: unexpected action %0d pos %0d stage %0d focus %0d score %0d last %0b",
                   $realtime, mon_seen.action, mon_seen.position, mon_seen.best_stage,
                   mon_seen.best_focus, mon_seen.best_score, mon_seen.last);
      end else begin
        mon_want = due_acts.pop_front();
        if (mon_seen.action !== mon_want.action || mon_seen.position !== mon_want.position ||
            mon_seen.best_stage !== mon_want.best_stage ||
            mon_seen.best_focus !== mon_want.best_focus ||
            mon_seen.best_score !== mon_want.best_score || mon_seen.last !== mon_want.last) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display({"%0t: action differs: expected act %0d pos %0d stage %0d focus %0d ",
                      "score %0d last %0b, got act %0d pos %0d stage %0d focus %0d ",
                      "score %0d last %0b"},
                     $realtime, mon_want.action, mon_want.position, mon_want.best_stage,
                     mon_want.best_focus, mon_want.best_score, mon_want.last,
                     mon_seen.action, mon_seen.position, mon_seen.best_stage,
                     mon_seen.best_focus, mon_seen.best_score, mon_seen.last);
        end
      end
      mon_wait = draw_wait();
      if (mon_wait == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_hold  <= mon_wait;
      end
    end else if (!out_ready) begin
      if (out_hold <= 1) out_ready <= 1'b1;
      out_hold <= out_hold - 1;
    end
  end

  // Watchdog: a run that stops moving for too long has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    cmd       = CMD_TICK;
    score     = '0;
    out_ready = 1'b0;
    calm      = 1'b0;
    fail_cnt  = 0;
    taken_cnt = 0;
    idle_cycles = 0;

    // Shadow state after reset: everything zero except both steps.
    cfg_stage_start  = '0;
    cfg_stage_step   = 15'd1;
    cfg_stage_stop   = '0;
    cfg_focus_start  = '0;
    cfg_focus_step   = 15'd1;
    cfg_focus_stop   = '0;
    cfg_stage_settle = '0;
    cfg_focus_settle = '0;
    sw_phase     = PH_IDLE;
    cur_stage_p  = '0;
    cur_focus_p  = '0;
    best_stage_p = '0;
    best_focus_p = '0;
    best_score_p = '0;
    best_ok      = 1'b0;
    settle_left  = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset registers, a single-frame sweep, and events arriving out of place:
    // tick and score while idle, the unused code, start mid-sweep, tick while
    // waiting for a score.
    queue_event(CMD_TICK, 16'h0000);
    queue_event(CMD_SCORE, 16'h1234);
    queue_event(CMD_NONE, 16'hFFFF);
    queue_event(CMD_START, 16'h0000);
    queue_event(CMD_START, 16'h5A5A);
    queue_event(CMD_TICK, 16'h0000);
    queue_event(CMD_TICK, 16'h0000);
    queue_event(CMD_TICK, 16'hFFFF);
    queue_event(CMD_START, 16'h0000);
    queue_event(CMD_SCORE, 16'hFFFF);
    queue_event(CMD_TICK, 16'h0000);
    quiesce();

    // Extremes: stage rows at -32768, -1 and 32766 with the next row past the
    // top, focus pinned at 32767 with a zero step that must act as one and
    // must not wrap. Scores 0, max, max: the tie must not move the best.
    apb_write(REG_STAGE_START, -32768);
    apb_write(REG_STAGE_STEP, 32767);
    apb_write(REG_STAGE_STOP, 32767);
    apb_write(REG_FOCUS_START, 32767);
    apb_write(REG_FOCUS_STEP, 0);
    apb_write(REG_FOCUS_STOP, 32767);
    apb_write(REG_STAGE_SETTLE, 0);
    apb_write(REG_FOCUS_SETTLE, 1);
    @(negedge clk);
    queue_event(CMD_START, 16'h0000);
    phase_goal = 0;
    while (sw_phase != PH_IDLE) begin
      if (sw_phase == PH_WAIT_SCORE) begin
        queue_event(CMD_SCORE, (phase_goal == 0) ? 16'h0000 : 16'hFFFF);
        phase_goal++;
      end else begin
        queue_event(CMD_TICK, 16'h0000);
      end
    end
    quiesce();

    // Random part: retune between bursts, mostly proper sweeps with some noise.
    taken_cnt = 0;
    while (taken_cnt < RANDOM_EVENTS) begin
      retune();
      calm = ($urandom_range(0, 4) == 0);
      @(negedge clk);
      phase_goal = taken_cnt + int'($urandom_range(15, 50));
      while (taken_cnt < phase_goal) begin
        if ($urandom_range(0, 99) < 15)
          queue_event(cmd_t'($urandom_range(0, 3)), 16'($urandom()));
        else
          queue_proper();
      end
      quiesce();
    end

    // Long settle counts on a one-frame sweep, run without idling. Drop the
    // stage settle back to zero before the final move so it is counted once.
    calm = 1'b1;
    while (sw_phase != PH_IDLE) queue_proper();
    quiesce();
    apb_write(REG_STAGE_STOP, cfg_stage_start);
    apb_write(REG_FOCUS_STOP, cfg_focus_start);
    apb_write(REG_STAGE_SETTLE, LONG_SETTLE);
    apb_write(REG_FOCUS_SETTLE, LONG_SETTLE);
    @(negedge clk);
    queue_event(CMD_START, 16'h0000);
    while (sw_phase != PH_WAIT_SCORE) queue_proper();
    quiesce();
    apb_write(REG_STAGE_SETTLE, 0);
    @(negedge clk);
    while (sw_phase != PH_IDLE) queue_proper();
    quiesce();

    // Let any stray result surface before the verdict.
    repeat (16) @(posedge clk);
    if (fail_cnt == 0 && due_acts.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
